### src/lcc_pkg.sv
// Shared types, class codes and digit helpers for the card number classifier.
// No dependencies.
package lcc_pkg;

  localparam int IN_W = 63;

  typedef logic [3:0] digit_t;
  typedef logic [1:0] card_class_t;

  localparam card_class_t CLASS_FIFTEEN = 2'd0;
  localparam card_class_t CLASS_SIXTEEN = 2'd1;
  localparam card_class_t CLASS_FOUR    = 2'd2;
  localparam card_class_t CLASS_INVALID = 2'd3;

  // Controls for one digit cell of the chain.
  typedef struct packed {
    logic clr;     // clear digit
    logic dabble;  // add-3 adjust and shift in one binary bit
    logic shift;   // take the digit of the upper neighbor
  } lcc_cell_ctrl_t;

  // Controls for the Luhn accumulator.
  typedef struct packed {
    logic clr;
    logic step;
  } lcc_acc_ctrl_t;

  // Doubled digit with its decimal digits summed.
  function automatic digit_t dbl_digit(input digit_t d);
    digit_t r;
    case (d)
      4'd0:    r = 4'd0;
      4'd1:    r = 4'd2;
      4'd2:    r = 4'd4;
      4'd3:    r = 4'd6;
      4'd4:    r = 4'd8;
      4'd5:    r = 4'd1;
      4'd6:    r = 4'd3;
      4'd7:    r = 4'd5;
      4'd8:    r = 4'd7;
      4'd9:    r = 4'd9;
      default: r = 4'd0;
    endcase
    return r;
  endfunction

endpackage

### src/lcc_digit_cell.sv
// One BCD digit cell of the conversion chain: double-dabble step or digit shift.
// Depends on lcc_pkg.
module lcc_digit_cell import lcc_pkg::*; (
  input  logic           clk,
  input  lcc_cell_ctrl_t ctrl,
  input  logic           bit_in,
  input  digit_t         digit_in,
  output logic           bit_out,
  output digit_t         digit_out
);

  digit_t digit_r, digit_nxt;
  digit_t adj;

  assign adj     = (digit_r >= 4'd5) ? digit_r + 4'd3 : digit_r;
  assign bit_out = adj[3];

  always_comb begin
    digit_nxt = digit_r;
    if (ctrl.clr) begin
      digit_nxt = '0;
    end else if (ctrl.dabble) begin
      digit_nxt = {adj[2:0], bit_in};
    end else if (ctrl.shift) begin
      digit_nxt = digit_in;
    end
  end

  always_ff @(posedge clk) begin
    digit_r <= digit_nxt;
  end

  assign digit_out = digit_r;

endmodule

### src/lcc_luhn_acc.sv
// Luhn accumulator at the bottom of the chain: sum mod 10, digit count, leading digits.
// Depends on lcc_pkg.
module lcc_luhn_acc import lcc_pkg::*; #(
  parameter int CNT_W = 5
) (
  input  logic          clk,
  input  logic          rst_n,
  input  lcc_acc_ctrl_t ctrl,
  input  digit_t        digit,
  output logic          sum_ok,
  output card_class_t   card_class
);

  logic [CNT_W-1:0] pos_r, pos_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  digit_t           acc_r, acc_nxt;
  digit_t           lead_r, lead_nxt;
  digit_t           second_r, second_nxt;
  digit_t           prev_r, prev_nxt;
  digit_t           term;
  logic [4:0]       acc_sum;

  // position is 1-based; even positions get doubled
  assign term    = pos_nxt[0] ? digit : dbl_digit(digit);
  assign acc_sum = {1'b0, acc_r} + {1'b0, term};

  always_comb begin
    pos_nxt    = pos_r + 1'b1;
    acc_nxt    = acc_r;
    count_nxt  = count_r;
    lead_nxt   = lead_r;
    second_nxt = second_r;
    prev_nxt   = prev_r;
    if (ctrl.step) begin
      acc_nxt  = (acc_sum >= 5'd10) ? 4'(acc_sum - 5'd10) : acc_sum[3:0];
      prev_nxt = digit;
      if (digit != '0) begin
        count_nxt  = pos_nxt;
        lead_nxt   = digit;
        second_nxt = prev_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || ctrl.clr) begin
      pos_r    <= '0;
      acc_r    <= '0;
      count_r  <= '0;
      lead_r   <= '0;
      second_r <= '0;
      prev_r   <= '0;
    end else if (ctrl.step) begin
      pos_r    <= pos_nxt;
      acc_r    <= acc_nxt;
      count_r  <= count_nxt;
      lead_r   <= lead_nxt;
      second_r <= second_nxt;
      prev_r   <= prev_nxt;
    end
  end

  always_comb begin
    sum_ok     = (count_r != '0) && (acc_r == '0);
    card_class = CLASS_INVALID;
    if (sum_ok) begin
      if (count_r == CNT_W'(15) && lead_r == 4'd3 && (second_r == 4'd4 || second_r == 4'd7))
      begin
        card_class = CLASS_FIFTEEN;
      end else if (count_r == CNT_W'(16) && lead_r == 4'd5 &&
                   second_r >= 4'd1 && second_r <= 4'd5) begin
        card_class = CLASS_SIXTEEN;
      end else if (lead_r == 4'd4 && (count_r == CNT_W'(13) || count_r == CNT_W'(16))) begin
        card_class = CLASS_FOUR;
      end
    end
  end

endmodule

### src/luhn_card_number_classifier.sv
// Top level of the Luhn card number classifier: digit cell chain, accumulator, control.
// Depends on lcc_pkg, lcc_digit_cell and lcc_luhn_acc.
// Flow: a bit-serial double-dabble pass over the chain, then a digit-serial Luhn pass and a
// finishing step; out_valid is a registered strobe raised after the finishing step.
// Start is taken only while idle, so items never overlap; the out_valid cycle is already idle.
// Reset (rst_n low, synchronous) returns to idle and drops any item in flight.
module luhn_card_number_classifier import lcc_pkg::*; #(
  parameter int MAX_DIGITS = 19
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  input  logic [IN_W-1:0] in_card_number,
  output logic            out_valid,
  output card_class_t     out_card_class,
  output logic            out_checksum_ok
);

  localparam int CNT_W  = $clog2(MAX_DIGITS + 1);
  localparam int STEP_W = $clog2(IN_W);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CONV = 2'd1;
  localparam logic [1:0] ST_LUHN = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  logic [1:0]        state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [IN_W-1:0]   bin_r, bin_nxt;
  logic              ovf_r, ovf_nxt;
  logic              out_valid_r;
  card_class_t       out_card_class_r;
  logic              out_checksum_ok_r;
  logic              accept;

  lcc_cell_ctrl_t    cell_ctrl;
  lcc_acc_ctrl_t     acc_ctrl;
  logic              bit_w [MAX_DIGITS+1];
  digit_t            digit_w [MAX_DIGITS];
  logic              acc_ok;
  card_class_t       acc_class;

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;

  assign cell_ctrl.clr    = accept;
  assign cell_ctrl.dabble = (state_r == ST_CONV);
  assign cell_ctrl.shift  = (state_r == ST_LUHN);
  assign acc_ctrl.clr     = accept;
  assign acc_ctrl.step    = (state_r == ST_LUHN);

  assign bit_w[0] = bin_r[IN_W-1];

  genvar gi;
  generate
    for (gi = 0; gi < MAX_DIGITS; gi++) begin : g_cell
      digit_t upper;
      if (gi == MAX_DIGITS - 1) begin : g_top
        assign upper = '0;
      end else begin : g_mid
        assign upper = digit_w[gi+1];
      end
      lcc_digit_cell u_cell (
        .clk       (clk),
        .ctrl      (cell_ctrl),
        .bit_in    (bit_w[gi]),
        .digit_in  (upper),
        .bit_out   (bit_w[gi+1]),
        .digit_out (digit_w[gi])
      );
    end
  endgenerate

  lcc_luhn_acc #(.CNT_W(CNT_W)) u_acc (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl       (acc_ctrl),
    .digit      (digit_w[0]),
    .sum_ok     (acc_ok),
    .card_class (acc_class)
  );

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r + 1'b1;
    bin_nxt   = bin_r;
    ovf_nxt   = ovf_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_CONV;
          step_nxt  = '0;
          bin_nxt   = in_card_number;
          ovf_nxt   = 1'b0;
        end
      end
      ST_CONV: begin
        bin_nxt = {bin_r[IN_W-2:0], 1'b0};
        // a bit leaving the top cell means the number has too many digits
        ovf_nxt = ovf_r | bit_w[MAX_DIGITS];
        if (step_r == STEP_W'(IN_W - 1)) begin
          state_nxt = ST_LUHN;
          step_nxt  = '0;
        end
      end
      ST_LUHN: begin
        if (step_r == STEP_W'(MAX_DIGITS - 1)) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (state_r == ST_FIN);
    end
  end

  always_ff @(posedge clk) begin
    step_r <= step_nxt;
    bin_r  <= bin_nxt;
    ovf_r  <= ovf_nxt;
    if (state_r == ST_FIN) begin
      out_checksum_ok_r <= acc_ok && !ovf_r;
      out_card_class_r  <= ovf_r ? CLASS_INVALID : acc_class;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_card_class  = out_card_class_r;
  assign out_checksum_ok = out_checksum_ok_r;

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("accepted item did not raise busy");

  a_valid_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_valid_after_fin: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r) == ST_FIN)
    else $error("result strobe without finishing step");

  a_class_needs_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_checksum_ok |-> out_card_class == CLASS_INVALID)
    else $error("class given for failed checksum");

endmodule
